// ===== design/fbpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  // fixed widths of the register and item fields
  localparam int ADDR_W   = 32;
  localparam int BSIZE_W  = 16;
  localparam int ALIGN_W  = 4;
  localparam int COUNT_W  = 9;
  localparam int SIZE_W   = 17;
  localparam int PROD_W   = 2 * SIZE_W;
  localparam int CALC_W   = 64;
  localparam int Q_W      = COUNT_W;
  localparam int DIVD_W   = COUNT_W + SIZE_W;
  localparam int DCNT_W   = 4;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = 32'd0;
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST  = 16'd8;
  localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RST  = 4'd3;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_SHUT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOT_INIT = 3'd2,
    ST_BAD_ADDR = 3'd3,
    ST_BAD_CFG  = 3'd4,
    ST_ALREADY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_ALIGN_LOG2  = 2'd2,
    REG_BLOCK_COUNT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic    capture;
    logic    set_res;
    status_t status;
    logic    res_alloc;
    logic    pop;
    logic    push;
    logic    div_load;
    logic    div_step;
    logic    sweep_clr;
    logic    sweep_step;
    logic    init_done;
    logic    shut;
    logic    post;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ready;
    logic head_nil;
    logic cfg_bad;
    logic size_zero;
    logic out_of_range;
    logic div_last;
    logic sweep_last;
    logic free_bad;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/fixed_block_pool_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Allocate, free (9-step restoring divider), initialize (one link written per cycle)
// and shutdown each post one result. Shutdown and requests rejected at decode go
// straight from decode to posting, as does a free outside the pool once checked.
// One request in flight; the next is accepted in the cycle after the result is posted.
// Reset (rst_n low, synchronous) restores register defaults and an empty, uninitialized pool.
module fixed_block_pool_allocator_top #(
  parameter int MAX_BLOCKS      = 256,
  parameter int ADDRESS_WIDTH   = 32,
  parameter int MIN_BLOCK_BYTES = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire fbpa_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output fbpa_pkg::out_item_t               out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  wire logic [fbpa_pkg::PDATA_W-1:0] pwdata,
  output logic      [fbpa_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import fbpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .ADDRESS_WIDTH   (ADDRESS_WIDTH),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

endmodule

`default_nettype wire

// ===== design/fbpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire fbpa_pkg::dp_stat_t stat,
  output fbpa_pkg::dp_cmd_t       cmd
);
  import fbpa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_ALLOC    = 8'b0000_0100,
    S_FREE_CHK = 8'b0000_1000,
    S_FREE_DIV = 8'b0001_0000,
    S_FREE_END = 8'b0010_0000,
    S_SWEEP    = 8'b0100_0000,
    S_POST     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    cmd.status = ST_OK;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_POST;
        case (stat.op)
          OP_ALLOC: begin
            if (!stat.ready) begin
              cmd.set_res = 1'b1;
              cmd.status  = ST_NOT_INIT;
            end else if (stat.head_nil) begin
              cmd.set_res = 1'b1;
              cmd.status  = ST_EMPTY;
            end else begin
              state_nxt = S_ALLOC;
            end
          end
          OP_FREE: begin
            if (!stat.ready) begin
              cmd.set_res = 1'b1;
              cmd.status  = ST_NOT_INIT;
            end else if (stat.size_zero) begin
              cmd.set_res = 1'b1;
              cmd.status  = ST_BAD_ADDR;
            end else begin
              state_nxt = S_FREE_CHK;
            end
          end
          OP_INIT: begin
            if (stat.ready) begin
              cmd.set_res = 1'b1;
              cmd.status  = ST_ALREADY;
            end else if (stat.cfg_bad) begin
              cmd.set_res = 1'b1;
              cmd.status  = ST_BAD_CFG;
            end else begin
              cmd.sweep_clr = 1'b1;
              state_nxt     = S_SWEEP;
            end
          end
          OP_SHUT: begin
            cmd.set_res = 1'b1;
            if (!stat.ready) begin
              cmd.status = ST_NOT_INIT;
            end else begin
              cmd.shut   = 1'b1;
              cmd.status = ST_OK;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ALLOC: begin
        cmd.pop       = 1'b1;
        cmd.set_res   = 1'b1;
        cmd.res_alloc = 1'b1;
        cmd.status    = ST_OK;
        state_nxt     = S_POST;
      end
      S_FREE_CHK: begin
        if (stat.out_of_range) begin
          cmd.set_res = 1'b1;
          cmd.status  = ST_BAD_ADDR;
          state_nxt   = S_POST;
        end else begin
          cmd.div_load = 1'b1;
          state_nxt    = S_FREE_DIV;
        end
      end
      S_FREE_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FREE_END;
        end
      end
      S_FREE_END: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_POST;
        if (stat.free_bad) begin
          cmd.status = ST_BAD_ADDR;
        end else begin
          cmd.push   = 1'b1;
          cmd.status = ST_OK;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.init_done = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.status    = ST_OK;
          state_nxt     = S_POST;
        end
      end
      S_POST: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.post) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request did not enter decode");

  a_post_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!out_valid_r || out_ready))
    else $error("result posted over a pending result");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE_DIV && !stat.div_last) |=> (state_r == S_FREE_DIV))
    else $error("divider left before its last step");
`endif

endmodule

`default_nettype wire

// ===== design/fbpa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbpa_dp #(
  parameter int MAX_BLOCKS      = 256,
  parameter int ADDRESS_WIDTH   = 32,
  parameter int MIN_BLOCK_BYTES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fbpa_pkg::dp_cmd_t               cmd,
  output fbpa_pkg::dp_stat_t                   stat,
  input  wire fbpa_pkg::in_item_t              in_data,
  output fbpa_pkg::out_item_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fbpa_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [fbpa_pkg::PDATA_W-1:0]    pwdata,
  output logic      [fbpa_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);
  import fbpa_pkg::*;

  localparam int IW  = $clog2(MAX_BLOCKS + 1);
  localparam int AIW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int AW  = ADDRESS_WIDTH;

  localparam logic [IW-1:0]     NIL     = IW'(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] MAX_LIM = SIZE_W'(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] MIN_LIM = SIZE_W'(MIN_BLOCK_BYTES);

  // configuration registers
  logic [ADDR_W-1:0]  pool_base_r;
  logic [BSIZE_W-1:0] block_size_r;
  logic [ALIGN_W-1:0] align_log2_r;
  logic [COUNT_W-1:0] block_count_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= POOL_BASE_RST;
      block_size_r  <= BLOCK_SIZE_RST;
      align_log2_r  <= ALIGN_LOG2_RST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_POOL_BASE:   pool_base_r   <= pwdata[ADDR_W-1:0];
        REG_BLOCK_SIZE:  block_size_r  <= pwdata[BSIZE_W-1:0];
        REG_ALIGN_LOG2:  align_log2_r  <= pwdata[ALIGN_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_POOL_BASE:   prdata = PDATA_W'(pool_base_r);
      REG_BLOCK_SIZE:  prdata = PDATA_W'(block_size_r);
      REG_ALIGN_LOG2:  prdata = PDATA_W'(align_log2_r);
      REG_BLOCK_COUNT: prdata = PDATA_W'(block_count_r);
      default:         prdata = '0;
    endcase
  end

  // captured request
  op_t               op_r;
  logic [ADDR_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_data.operation;
      addr_r <= in_data.block_address;
    end
  end

  // pool state
  logic [IW-1:0]     head_r, head_nxt;
  logic              ready_r, ready_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  // effective block size from the live config
  logic [SIZE_W-1:0] align, amask, bsz, eff;
  logic              cfg_bad;

  always_comb begin
    align = SIZE_W'(1) << align_log2_r;
    amask = align - SIZE_W'(1);
    bsz   = SIZE_W'(block_size_r);
    if (align < bsz) begin
      eff = (bsz + amask) & ~amask;
    end else if (align > bsz) begin
      eff = align;
    end else begin
      eff = bsz;
    end
    cfg_bad = (block_size_r == '0) || (block_count_r == '0) ||
              (SIZE_W'(block_count_r) > MAX_LIM) || (eff < MIN_LIM);
  end

  // shared multiplier: index * size for allocate, count * size for the free bound
  logic [SIZE_W-1:0] mul_a;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [AW-1:0]     off_r;
  logic [CALC_W-1:0] sum, diff;
  logic [AW-1:0]     sum_aw, diff_aw;
  logic [ADDR_W-1:0] alloc_addr;

  assign mul_a    = (op_r == OP_ALLOC) ? SIZE_W'(head_r) : SIZE_W'(block_count_r);
  assign prod_nxt = mul_a * size_r;
  assign sum      = CALC_W'(pool_base_r) + CALC_W'(prod_r);
  assign sum_aw   = sum[AW-1:0];
  assign alloc_addr = ADDR_W'(sum_aw);
  assign diff     = CALC_W'(addr_r) - CALC_W'(pool_base_r);
  assign diff_aw  = diff[AW-1:0];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    off_r  <= diff_aw;
  end

  // restoring divider, one quotient bit a cycle
  logic [DIVD_W-1:0] rem_r, dvs_r;
  logic [Q_W-1:0]    q_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              ge;

  assign ge = rem_r >= dvs_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r     <= DIVD_W'(off_r);
      dvs_r     <= DIVD_W'(size_r) << (Q_W - 1);
      q_r       <= '0;
      div_cnt_r <= DCNT_W'(Q_W - 1);
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r     <= dvs_r >> 1;
      q_r       <= {q_r[Q_W-2:0], ge};
      div_cnt_r <= div_cnt_r - DCNT_W'(1);
    end
  end

  // init sweep
  logic [IW-1:0]     sweep_r;
  logic [SIZE_W-1:0] sweep_inc;
  logic              sweep_last;

  assign sweep_inc  = SIZE_W'(sweep_r) + SIZE_W'(1);
  assign sweep_last = sweep_inc == SIZE_W'(block_count_r);

  always_ff @(posedge clk) begin
    if (cmd.sweep_clr) begin
      sweep_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_r <= IW'(sweep_inc);
    end
  end

  // link store
  logic [IW-1:0]  link_mem [MAX_BLOCKS];
  logic [IW-1:0]  rd_data_r;
  logic           mem_we;
  logic [AIW-1:0] mem_waddr;
  logic [IW-1:0]  mem_wdata;

  assign mem_we    = cmd.sweep_step || cmd.push;
  assign mem_waddr = cmd.sweep_step ? sweep_r[AIW-1:0] : AIW'(q_r);
  assign mem_wdata = cmd.sweep_step ? (sweep_last ? NIL : IW'(sweep_inc)) : head_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= link_mem[head_r[AIW-1:0]];
  end

  always_comb begin
    head_nxt  = head_r;
    ready_nxt = ready_r;
    size_nxt  = size_r;
    if (cmd.pop) begin
      head_nxt = rd_data_r;
    end else if (cmd.push) begin
      head_nxt = IW'(q_r);
    end else if (cmd.init_done) begin
      head_nxt  = '0;
      ready_nxt = 1'b1;
      size_nxt  = eff;
    end else if (cmd.shut) begin
      head_nxt  = NIL;
      ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NIL;
      ready_r <= 1'b0;
      size_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      ready_r <= ready_nxt;
      size_r  <= size_nxt;
    end
  end

  // result and output registers
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  out_item_t         out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.status;
      res_addr_r   <= (cmd.res_alloc && cmd.status == ST_OK) ? alloc_addr : '0;
    end
    if (cmd.post) begin
      out_data_r.result_address <= res_addr_r;
      out_data_r.status         <= res_status_r;
    end
  end

  assign out_data = out_data_r;

  always_comb begin
    stat.op           = op_r;
    stat.ready        = ready_r;
    stat.head_nil     = head_r == NIL;
    stat.cfg_bad      = cfg_bad;
    stat.size_zero    = size_r == '0;
    stat.out_of_range = CALC_W'(off_r) >= CALC_W'(prod_r);
    stat.div_last     = div_cnt_r == '0;
    stat.sweep_last   = sweep_last;
    stat.free_bad     = (rem_r != '0) || (SIZE_W'(q_r) >= MAX_LIM);
  end

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (ready_r && head_r != NIL))
    else $error("pop from an empty or idle pool");

  a_shut_empties: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(ready_r) |-> (head_r == NIL))
    else $error("pool left ready state with a live free list");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.set_res && cmd.status != ST_OK) |=> (res_addr_r == '0))
    else $error("failed request carries a nonzero address");
`endif

endmodule

`default_nettype wire
